// ===== hdl/rtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package: constants, command codes and types for the rate task dispatcher.
package rtd_pkg;

    localparam int MAX_TASKS_DEFAULT = 16;

    localparam int CMD_W      = 2;
    localparam int PRIO_W     = 8;
    localparam int RATE_W     = 10;
    localparam int TIME_W     = 16;
    localparam int EXTRA_W    = 13;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int TICK_W     = 16;
    localparam int POS_W      = 5;
    localparam int TIDX_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int ACH_W      = 6;
    localparam int BUDGET_W   = 17;
    localparam int ENTRY_W    = PRIO_W + RATE_W + TIME_W;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEH_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_COUNT = 2'd2;

    localparam logic [RATE_W-1:0]  RATE_MIN      = 10'd50;
    localparam logic [RATE_W-1:0]  RATE_MAX      = 10'd1000;
    localparam logic [EXTRA_W-1:0] EXTRA_STEP_UP = 13'd100;
    localparam logic [EXTRA_W-1:0] EXTRA_MAX     = 13'd5000;
    localparam logic [EXTRA_W-1:0] EXTRA_STEP_DN = 13'd50;
    localparam logic [ACH_W-1:0]   ACH_LIMIT     = 6'd50;
    localparam int                 US_PER_SEC    = 1000000;

    typedef struct packed {
        logic [PRIO_W-1:0] priority_v;
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] allowed;
    } entry_t;

endpackage
`default_nettype wire

// ===== hdl/rtd_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Serial restoring divider, one quotient bit per cycle.
module rtd_divider
    import rtd_pkg::*;
#(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIVISOR_W-1:0], q_reg[DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[DIVIDEND_W-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = shifted - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = shifted;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ===== hdl/rate_task_dispatcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rate task dispatcher: two task tables, merged priority walk, budget and overrun tracking.
// Load: writes one table entry without leaving idle. Tick: a serial budget divide, then for each
// scanned entry a table read, a 20-bit serial interval divide and an evaluate step, and finally
// a step to close the loop. Report: resumes the walk. At most 32 entries per walk with the
// default table size. One transaction in work at a time; result held in an output register.
// Async active-low reset clears control state and last-run valid bits; tables are undefined.
module rate_task_dispatcher_core
    import rtd_pkg::*;
#(
    parameter int MAX_TASKS_PER_TABLE = MAX_TASKS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic                  table_select,
    input  wire logic [3:0]            entry_index,
    input  wire logic [PRIO_W-1:0]     entry_priority,
    input  wire logic [RATE_W-1:0]     entry_rate_hz,
    input  wire logic [TIME_W-1:0]     entry_time_allowed_us,
    input  wire logic [TIME_W-1:0]     time_taken_us,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       result_kind,
    output logic [POS_W-1:0]           task_position,
    output logic                       task_table,
    output logic [3:0]                 task_table_index,
    output logic                       task_slipped,
    output logic                       previous_overran,
    output logic [EXTRA_W-1:0]         extra_time_us
);

    localparam int AW     = (MAX_TASKS_PER_TABLE > 1) ? $clog2(MAX_TASKS_PER_TABLE) : 1;
    localparam int CW     = $clog2(MAX_TASKS_PER_TABLE + 1);
    localparam int NPOS   = 2 * MAX_TASKS_PER_TABLE;
    localparam int PW     = $clog2(NPOS);
    localparam int BDIV_W = 20;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_BUDGET = 7'b0000010,
        ST_PICK   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_EVAL   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    entry_t veh_mem [MAX_TASKS_PER_TABLE];
    entry_t com_mem [MAX_TASKS_PER_TABLE];
    logic [TICK_W-1:0] last_mem [NPOS];
    logic [NPOS-1:0] last_valid_reg;
    entry_t veh_rd_reg, com_rd_reg;
    logic [TICK_W-1:0] last_rd_reg;

    logic [RATE_W-1:0]  loop_rate_reg;
    logic [CW-1:0]      veh_count_reg, com_count_reg;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [CW-1:0]      vcur_reg, vcur_next, ccur_reg, ccur_next;
    logic [EXTRA_W-1:0] extra_reg, extra_next;
    logic [ACH_W-1:0]   ach_reg, ach_next;
    logic               na_reg, na_next;
    logic               pend_reg, pend_next;
    logic [TIME_W-1:0]  pend_allow_reg, pend_allow_next;
    logic               over_reg, over_next;
    logic               use_v_reg, use_v_next;
    entry_t             cur_reg, cur_next;
    logic [TICK_W-1:0]  dt_reg, dt_next;
    logic [PW-1:0]      pos_reg, pos_next;

    logic               ov_reg, ov_next;
    logic               ok_reg, ok_next;
    logic [POS_W-1:0]   op_reg, op_next;
    logic               ot_reg, ot_next;
    logic [3:0]         oi_reg, oi_next;
    logic               os_reg, os_next;
    logic               oo_reg, oo_next;
    logic [EXTRA_W-1:0] oe_reg, oe_next;

    logic               div_start;
    logic [BDIV_W-1:0]  div_dividend;
    logic [RATE_W-1:0]  div_divisor;
    logic               div_done;
    logic [BDIV_W-1:0]  div_q;

    logic               accept, v_ok, c_ok, pick_v;
    logic               rd_en;
    logic [AW-1:0]      vaddr, caddr;
    logic               last_we;
    logic [CW-1:0]      cfg_cnt;
    logic [RATE_W-1:0]  cfg_rate;
    logic [TICK_W+2:0]  ival;
    logic [TICK_W+2:0]  dt_ext;
    logic [EXTRA_W:0]   ext_up;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;

    rtd_divider #(.DIVIDEND_W(BDIV_W), .DIVISOR_W(RATE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // config
    always_comb
    begin
        cfg_rate = cfg_data;
        if (cfg_data < RATE_MIN)
            cfg_rate = RATE_MIN;
        else if (cfg_data > RATE_MAX)
            cfg_rate = RATE_MAX;
        if (32'(cfg_data[4:0]) > MAX_TASKS_PER_TABLE)
            cfg_cnt = CW'(MAX_TASKS_PER_TABLE);
        else
            cfg_cnt = CW'(cfg_data[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_rate_reg <= RATE_MIN;
            veh_count_reg <= '0;
            com_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LOOP_RATE: loop_rate_reg <= cfg_rate;
                CFG_VEH_COUNT: veh_count_reg <= cfg_cnt;
                CFG_COM_COUNT: com_count_reg <= cfg_cnt;
                default: ;
            endcase
        end
    end

    // table memories
    assign v_ok  = vcur_reg < veh_count_reg;
    assign c_ok  = ccur_reg < com_count_reg;
    assign vaddr = accept ? AW'(entry_index) : vcur_reg[AW-1:0];
    assign caddr = accept ? AW'(entry_index) : ccur_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD && 32'(entry_index) < MAX_TASKS_PER_TABLE)
        begin
            if (table_select)
                com_mem[caddr] <= {entry_priority, entry_rate_hz, entry_time_allowed_us};
            else
                veh_mem[vaddr] <= {entry_priority, entry_rate_hz, entry_time_allowed_us};
        end
        if (rd_en)
        begin
            veh_rd_reg <= veh_mem[vaddr];
            com_rd_reg <= com_mem[caddr];
            last_rd_reg <= last_mem[PW'(vcur_reg + ccur_reg)];
        end
        if (last_we)
            last_mem[pos_reg] <= tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_valid_reg <= '0;
        else if (last_we)
            last_valid_reg[pos_reg] <= 1'b1;
    end

    assign pick_v = v_ok && (!c_ok || veh_rd_reg.priority_v <= com_rd_reg.priority_v);

    always_comb
    begin
        ival   = (cur_reg.rate == '0 || div_q == '0) ? 19'd1 : 19'(div_q);
        dt_ext = 19'(dt_reg);
        ext_up = {1'b0, extra_reg} + {1'b0, EXTRA_STEP_UP};
    end

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        budget_next     = budget_reg;
        vcur_next       = vcur_reg;
        ccur_next       = ccur_reg;
        extra_next      = extra_reg;
        ach_next        = ach_reg;
        na_next         = na_reg;
        pend_next       = pend_reg;
        pend_allow_next = pend_allow_reg;
        over_next       = over_reg;
        use_v_next      = use_v_reg;
        cur_next        = cur_reg;
        dt_next         = dt_reg;
        pos_next        = pos_reg;
        ov_next         = ov_reg && out_stall;
        ok_next         = ok_reg;
        op_next         = op_reg;
        ot_next         = ot_reg;
        oi_next         = oi_reg;
        os_next         = os_reg;
        oo_next         = oo_reg;
        oe_next         = oe_reg;
        div_start       = 1'b0;
        div_dividend    = BDIV_W'(US_PER_SEC);
        div_divisor     = loop_rate_reg;
        rd_en           = 1'b0;
        last_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            vcur_next  = '0;
                            ccur_next  = '0;
                            pend_next  = 1'b0;
                            over_next  = 1'b0;
                            div_start  = 1'b1;
                            state_next = ST_BUDGET;
                        end
                        CMD_REPORT:
                        begin
                            if (pend_reg)
                            begin
                                pend_next = 1'b0;
                                over_next = time_taken_us > pend_allow_reg;
                                if ({1'b0, time_taken_us} >= budget_reg)
                                begin
                                    budget_next = '0;
                                    state_next  = ST_OUT;
                                end
                                else
                                begin
                                    budget_next = budget_reg - {1'b0, time_taken_us};
                                    state_next  = ST_PICK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUDGET:
            begin
                if (div_done)
                begin
                    budget_next = BUDGET_W'(div_q) + BUDGET_W'(extra_reg);
                    state_next  = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (!v_ok && !c_ok)
                    state_next = ST_OUT;
                else
                begin
                    rd_en      = 1'b1;
                    pos_next   = PW'(vcur_reg + ccur_reg);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                use_v_next = pick_v;
                cur_next   = pick_v ? veh_rd_reg : com_rd_reg;
                dt_next    = tick_reg - (last_valid_reg[pos_reg] ? last_rd_reg : '0);
                if (pick_v)
                    vcur_next = vcur_reg + 1'b1;
                else
                    ccur_next = ccur_reg + 1'b1;
                div_start    = 1'b1;
                div_dividend = BDIV_W'(loop_rate_reg);
                div_divisor  = pick_v ? veh_rd_reg.rate : com_rd_reg.rate;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (dt_ext < ival)
                    state_next = ST_PICK;
                else
                begin
                    if (dt_ext >= (ival << 2))
                        na_next = 1'b1;
                    if (BUDGET_W'(cur_reg.allowed) > budget_reg)
                        state_next = ST_PICK;
                    else
                    begin
                        pend_next       = 1'b1;
                        pend_allow_next = cur_reg.allowed;
                        last_we         = 1'b1;
                        ov_next         = 1'b1;
                        ok_next         = 1'b0;
                        op_next         = POS_W'(pos_reg);
                        ot_next         = !use_v_reg;
                        oi_next         = use_v_reg ? 4'(vcur_reg - 1'b1)
                                                    : 4'(ccur_reg - 1'b1);
                        os_next         = dt_ext >= (ival << 1);
                        oo_next         = over_reg;
                        oe_next         = extra_reg;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                pend_next = 1'b0;
                if (na_reg)
                begin
                    extra_next = (ext_up > {1'b0, EXTRA_MAX}) ? EXTRA_MAX
                                                              : ext_up[EXTRA_W-1:0];
                    na_next    = 1'b0;
                    ach_next   = '0;
                end
                else if (extra_reg != '0)
                begin
                    ach_next = ach_reg + 1'b1;
                    if (ach_reg + 1'b1 > ACH_LIMIT)
                    begin
                        ach_next   = '0;
                        extra_next = (extra_reg > EXTRA_STEP_DN) ? extra_reg - EXTRA_STEP_DN
                                                                 : '0;
                    end
                end
                ov_next    = 1'b1;
                ok_next    = 1'b1;
                op_next    = '0;
                ot_next    = 1'b0;
                oi_next    = '0;
                os_next    = 1'b0;
                oo_next    = over_reg;
                oe_next    = extra_next;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            budget_reg <= '0;
            vcur_reg  <= '0;
            ccur_reg  <= '0;
            extra_reg <= '0;
            ach_reg   <= '0;
            na_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            pend_allow_reg <= '0;
            over_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            budget_reg <= budget_next;
            vcur_reg  <= vcur_next;
            ccur_reg  <= ccur_next;
            extra_reg <= extra_next;
            ach_reg   <= ach_next;
            na_reg    <= na_next;
            pend_reg  <= pend_next;
            pend_allow_reg <= pend_allow_next;
            over_reg  <= over_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        use_v_reg <= use_v_next;
        cur_reg   <= cur_next;
        dt_reg    <= dt_next;
        pos_reg   <= pos_next;
        ok_reg    <= ok_next;
        op_reg    <= op_next;
        ot_reg    <= ot_next;
        oi_reg    <= oi_next;
        os_reg    <= os_next;
        oo_reg    <= oo_next;
        oe_reg    <= oe_next;
    end

    assign out_valid        = ov_reg;
    assign result_kind      = ok_reg;
    assign task_position    = op_reg;
    assign task_table       = ot_reg;
    assign task_table_index = oi_reg;
    assign task_slipped     = os_reg;
    assign previous_overran = oo_reg;
    assign extra_time_us    = oe_reg;

endmodule
`default_nettype wire

// ===== hdl/rtd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the rate task dispatcher, bound to the top level.
module rtd_checker
    import rtd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               result_kind,
    input wire logic [POS_W-1:0]   task_position,
    input wire logic               task_slipped,
    input wire logic [EXTRA_W-1:0] extra_time_us
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(task_position))
        else $error("result changed while stalled");

    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_extra_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> extra_time_us <= EXTRA_MAX)
        else $error("extra time above limit");

    a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> task_position == '0 && !task_slipped)
        else $error("loop finished result carries task fields");

endmodule

bind rate_task_dispatcher_core rtd_checker u_rtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .task_position (task_position),
    .task_slipped  (task_slipped),
    .extra_time_us (extra_time_us)
);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rate task dispatcher with random traffic and stalls.
module tb;
    import rtd_pkg::*;

    localparam int NTASK      = 16;
    localparam int SETTLE_CYC = 700;
    localparam int CYCLE_CAP  = 4000000;

    typedef struct {
        bit        kind;
        bit [4:0]  pos;
        bit        tbl;
        bit [3:0]  idx;
        bit        slip;
        bit        over;
        bit [12:0] extra;
    } dispatch_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CMD_W-1:0] command = CMD_LOAD;
    logic table_select = 1'b0;
    logic [3:0] entry_index = '0;
    logic [PRIO_W-1:0] entry_priority = '0;
    logic [RATE_W-1:0] entry_rate_hz = '0;
    logic [TIME_W-1:0] entry_time_allowed_us = '0;
    logic [TIME_W-1:0] time_taken_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic result_kind;
    logic [POS_W-1:0] task_position;
    logic task_table;
    logic [3:0] task_table_index;
    logic task_slipped;
    logic previous_overran;
    logic [EXTRA_W-1:0] extra_time_us;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    rate_task_dispatcher_core u_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    entry_t      veh_tab [NTASK];
    entry_t      com_tab [NTASK];
    bit [15:0]   run_stamp [2*NTASK];
    bit [15:0]   ticks;
    int unsigned budget;
    int unsigned cur_v, cur_c;
    int unsigned extra_us;
    int unsigned ach_run;
    bit          late_flag;
    bit          pend;
    int unsigned pend_allowed;
    int unsigned loop_hz;
    int unsigned veh_cnt, com_cnt;

    dispatch_t expected_dispatches[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    function automatic void post(bit k, bit [4:0] p, bit t, bit [3:0] i, bit s, bit o);
        dispatch_t d;
        d.kind = k; d.pos = p; d.tbl = t; d.idx = i; d.slip = s; d.over = o;
        d.extra = extra_us[12:0];
        expected_dispatches.push_back(d);
    endfunction

    function automatic void close_loop(bit over);
        pend = 0;
        if (late_flag) begin
            extra_us = (extra_us + 100 > 5000) ? 5000 : extra_us + 100;
            late_flag = 0;
            ach_run = 0;
        end else if (extra_us > 0) begin
            ach_run++;
            if (ach_run > 50) begin
                ach_run = 0;
                extra_us = (extra_us > 50) ? extra_us - 50 : 0;
            end
        end
        post(1, 0, 0, 0, 0, over);
    endfunction

    function automatic void walk_tables(bit over);
        bit v_ok, c_ok, use_v;
        entry_t e;
        int unsigned p, ivl, dt;
        forever begin
            v_ok = cur_v < veh_cnt;
            c_ok = cur_c < com_cnt;
            if (!v_ok && !c_ok) begin
                close_loop(over);
                return;
            end
            use_v = (v_ok && c_ok) ? (veh_tab[cur_v].priority_v <= com_tab[cur_c].priority_v)
                                   : v_ok;
            e = use_v ? veh_tab[cur_v] : com_tab[cur_c];
            p = cur_v + cur_c;
            if (use_v) cur_v++; else cur_c++;
            ivl = (e.rate == 0) ? 1 : loop_hz / e.rate;
            if (ivl < 1) ivl = 1;
            dt = 16'(ticks - run_stamp[p]);
            if (dt < ivl) continue;
            if (dt >= ivl * 4) late_flag = 1;
            if (e.allowed > budget) continue;
            pend = 1;
            pend_allowed = e.allowed;
            run_stamp[p] = ticks;
            post(0, p[4:0], !use_v, use_v ? cur_v[3:0] - 4'd1 : cur_c[3:0] - 4'd1,
                 dt >= ivl * 2, over);
            return;
        end
    endfunction

    function automatic void predict_txn(bit [1:0] cmd, bit tsel, bit [3:0] idx,
                                        bit [7:0] prio, bit [9:0] rate, bit [15:0] allw,
                                        bit [15:0] taken);
        entry_t e;
        bit ov;
        e.priority_v = prio; e.rate = rate; e.allowed = allw;
        case (cmd)
            CMD_LOAD: if (tsel) com_tab[idx] = e; else veh_tab[idx] = e;
            CMD_TICK: begin
                ticks++;
                budget = 1000000 / loop_hz + extra_us;
                cur_v = 0; cur_c = 0; pend = 0;
                walk_tables(0);
            end
            CMD_REPORT: if (pend) begin
                pend = 0;
                ov = taken > pend_allowed;
                if (taken >= budget) begin
                    budget = 0;
                    close_loop(ov);
                end else begin
                    budget -= taken;
                    walk_tables(ov);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_txn(bit [1:0] cmd, bit tsel = 0, bit [3:0] idx = 0, bit [7:0] prio = 0,
                            bit [9:0] rate = 0, bit [15:0] allw = 0, bit [15:0] taken = 0);
        @(negedge clk);
        command <= cmd; table_select <= tsel; entry_index <= idx; entry_priority <= prio;
        entry_rate_hz <= rate; entry_time_allowed_us <= allw; time_taken_us <= taken;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_txn(cmd, tsel, idx, prio, rate, allw, taken);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_dispatches.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] ri, bit [9:0] val);
        @(negedge clk);
        cfg_write <= 1'b1; cfg_index <= ri; cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (ri == CFG_LOOP_RATE)
            loop_hz = (val < 50) ? 50 : (val > 1000) ? 1000 : val;
        else if (ri == CFG_VEH_COUNT || ri == CFG_COM_COUNT) begin
            if (ri == CFG_VEH_COUNT) veh_cnt = (val[4:0] > 16) ? 16 : val[4:0];
            else com_cnt = (val[4:0] > 16) ? 16 : val[4:0];
        end
    endtask

    function automatic bit [9:0] pick_rate();
        case ($urandom_range(3))
            0: return 10'($urandom_range(0, 1000));
            1: return 10'($urandom_range(0, 12));
            2: return 10'($urandom_range(1, 4) * 25);
            default: return 0;
        endcase
    endfunction

    function automatic bit [15:0] pick_allowed();
        if ($urandom_range(99) < 20) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 3000));
    endfunction

    task automatic load_random(bit tsel, bit [3:0] idx);
        send_txn(CMD_LOAD, tsel, idx, 8'($urandom_range(1) ? $urandom_range(0, 255)
                 : $urandom_range(0, 3)), pick_rate(), pick_allowed());
    endtask

    task automatic test_idle_block();
        send_txn(CMD_TICK);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'd500);
        send_txn(CMD_UNKNOWN, 1, 4'hF, 8'hFF, 10'h3FF, 16'hFFFF, 16'hFFFF);
        send_txn(CMD_TICK);
        settle();
    endtask

    task automatic test_load_tables();
        for (int i = 0; i < NTASK; i++) begin
            send_txn(CMD_LOAD, 0, 4'(i), (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'(i * 9),
                     (i == 2) ? 10'd1000 : (i == 3) ? 10'd1 : 10'(i % 3),
                     (i == 4) ? 16'hFFFF : 16'(i * 100));
            send_txn(CMD_LOAD, 1, 4'(i), (i == 0) ? 8'd0 : 8'(i * 9 + 2),
                     (i == 5) ? 10'd1000 : 10'(i % 4), (i == 6) ? 16'hFFFF : 16'(i * 50));
        end
        settle();
    endtask

    task automatic test_register_limits();
        write_reg(CFG_LOOP_RATE, 10'd0);
        write_reg(CFG_VEH_COUNT, 10'd31);
        write_reg(CFG_COM_COUNT, 10'h3FF);
        write_reg(CFG_UNUSED, 10'h155);
        send_txn(CMD_TICK);
        settle();
        write_reg(CFG_LOOP_RATE, 10'h3FF);
        send_txn(CMD_TICK);
        settle();
    endtask

    task automatic test_directed_loop();
        write_reg(CFG_LOOP_RATE, 10'd50);
        write_reg(CFG_VEH_COUNT, 10'd16);
        write_reg(CFG_COM_COUNT, 10'd16);
        send_txn(CMD_TICK);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'd0);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'd400);
        send_txn(CMD_TICK);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'd1);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'hFFFF);
        send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'd3);
        send_txn(CMD_TICK);
        settle();
    endtask

    task automatic random_items(int n);
        int done;
        int r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (pend && r < 80) begin
                case ($urandom_range(5))
                    0: send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'hFFFF);
                    1: send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'($urandom_range(0, 65535)));
                    default: send_txn(CMD_REPORT, 0, 0, 0, 0, 0,
                                      16'($urandom_range(0, pend_allowed + 300)));
                endcase
                done++;
            end else if (r < 8) begin
                load_random(1'($urandom_range(1)), 4'($urandom_range(15)));
                done++;
            end else if (r < 11) begin
                send_txn(CMD_UNKNOWN, 1'($urandom_range(1)), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 10'($urandom_range(1023)),
                         16'($urandom_range(65535)), 16'($urandom_range(65535)));
            end else if (r < 14) begin
                if (pend) done++;
                send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'($urandom_range(0, 65535)));
            end else begin
                send_txn(CMD_TICK);
                done++;
            end
        end
        settle();
    endtask

    task automatic test_random_phases();
        int rates [4] = '{50, 1000, 400, 123};
        int sp [4] = '{0, 46, 0, 22};
        int rp [4] = '{0, 0, 46, 22};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = sp[ph];
            stall_pct = rp[ph];
            write_reg(CFG_LOOP_RATE, 10'(rates[ph]));
            write_reg(CFG_VEH_COUNT, 10'((ph == 0) ? 16 : $urandom_range(0, 16)));
            write_reg(CFG_COM_COUNT, 10'((ph == 1) ? 0 : $urandom_range(0, 16)));
            random_items(85);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_VEH_COUNT, 10'd16);
        write_reg(CFG_COM_COUNT, 10'd16);
        @(posedge clk);
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++) begin
            send_txn(CMD_TICK);
            if (pend) send_txn(CMD_REPORT, 0, 0, 0, 0, 0, 16'($urandom_range(0, 800)));
        end
        settle();
        random_items(30);
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        dispatch_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_dispatches.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result kind=%0d pos=%0d", result_kind,
                             task_position);
            end else begin
                e = expected_dispatches.pop_front();
                if (result_kind !== e.kind || task_position !== e.pos
                    || task_table !== e.tbl || task_table_index !== e.idx
                    || task_slipped !== e.slip || previous_overran !== e.over
                    || extra_time_us !== e.extra) begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: exp kind=%0d pos=%0d tbl=%0d idx=%0d slip=%0d ",
                                  "over=%0d extra=%0d / got %0d %0d %0d %0d %0d %0d %0d"},
                                 e.kind, e.pos, e.tbl, e.idx, e.slip, e.over, e.extra,
                                 result_kind, task_position, task_table, task_table_index,
                                 task_slipped, previous_overran, extra_time_us);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        ticks = 0; budget = 0; cur_v = 0; cur_c = 0; extra_us = 0; ach_run = 0;
        late_flag = 0; pend = 0; pend_allowed = 0; loop_hz = 50; veh_cnt = 0; com_cnt = 0;
        foreach (run_stamp[i]) run_stamp[i] = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_idle_block();
        test_load_tables();
        test_register_limits();
        test_directed_loop();
        test_random_phases();
        test_backpressure();
        if (errors == 0 && expected_dispatches.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
